@@ rtl/srdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdt_pkg: shared types and constants of the region descriptor table
// Entry layout, request kinds and error codes.
// ----------------------------------------------------------------------------
package srdt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_FIND   = 3'd3;
    localparam logic [2:0] KIND_CHECK  = 3'd4;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_MISS  = 2'd3;

    typedef struct packed {
        logic [15:0] dev;
        logic [63:0] base;
        logic [63:0] len;
    } t_entry;

    // Compare results of one entry pair.
    typedef struct packed {
        logic less_ab;
        logic less_ba;
        logic equal;
        logic overlap;
    } t_cmp;

endpackage

@@ rtl/srdt_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdt_cmp: shared region compare unit
// Orders two regions and tests them for overlap; ends taken as 65-bit sums.
// ----------------------------------------------------------------------------
module srdt_cmp (
    input  srdt_pkg::t_entry i_a,
    input  srdt_pkg::t_entry i_b,
    output srdt_pkg::t_cmp   o_cmp
);
    logic [64:0] w_end_a;
    logic [64:0] w_end_b;
    logic        w_same_dev;

    // Compute exact ends
    assign w_end_a    = {1'b0, i_a.base} + {1'b0, i_a.len};
    assign w_end_b    = {1'b0, i_b.base} + {1'b0, i_b.len};
    assign w_same_dev = (i_a.dev == i_b.dev);

    // Order by device, base, length
    always_comb begin
        if (!w_same_dev) begin
            o_cmp.less_ab = i_a.dev < i_b.dev;
            o_cmp.less_ba = i_b.dev < i_a.dev;
        end else if (i_a.base != i_b.base) begin
            o_cmp.less_ab = i_a.base < i_b.base;
            o_cmp.less_ba = i_b.base < i_a.base;
        end else begin
            o_cmp.less_ab = i_a.len < i_b.len;
            o_cmp.less_ba = i_b.len < i_a.len;
        end
        o_cmp.equal   = (i_a == i_b);
        o_cmp.overlap = w_same_dev && !(w_end_a <= {1'b0, i_b.base})
                        && !(w_end_b <= {1'b0, i_a.base});
    end
endmodule

@@ rtl/sorted_region_descriptor_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_descriptor_table: region descriptor table with overlap check
// Sequenced table of device/base/length regions in one memory.
// ----------------------------------------------------------------------------
// One request at a time: o_in_stall stays high from the accepted request beat
// until its result beat is taken. A sequencer walks the table memory through
// the shared compare unit, visiting each entry in a registered read state and
// then a compare or move state. A query or find scans upward from entry 0, a
// remove shifts the entries above the removed one down, a sorted add scans up
// to the insert point and then shifts entries up from the top through the move
// state, an unsorted add writes at the end without a walk, and the table check
// compares each adjacent pair in sorted mode or every pair in unsorted mode.
// The result beat is raised from the done state.
module sorted_region_descriptor_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_device_id,
    input  logic [63:0] i_base_address,
    input  logic [63:0] i_region_length,
    input  logic [7:0]  i_entry_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [6:0]  o_result_index,
    output logic [6:0]  o_entry_count,
    output logic [1:0]  o_error
);
    localparam int IW = srdt_pkg::IDX_W;
    localparam int CW = srdt_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_MOVE, S_DONE
    } t_state;

    t_state              r_state;
    logic                r_sorted;
    logic [CW-1:0]       r_count;
    logic [2:0]          r_kind;
    srdt_pkg::t_entry    r_req;
    srdt_pkg::t_entry    r_ref;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    logic [CW-1:0]       r_pos;
    srdt_pkg::t_entry    r_rd;
    srdt_pkg::t_entry    mem [srdt_pkg::CAPACITY];

    logic                r_we;
    logic [IW-1:0]       r_wa;
    srdt_pkg::t_entry    r_wd;
    logic [IW-1:0]       w_ra;
    srdt_pkg::t_cmp      w_cmp;
    srdt_pkg::t_entry    w_a;

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        r_rd <= mem[w_ra];
    end

    // Read address is r_i; a check reads its pair partner r_j when r_j is nonzero
    always_comb begin
        w_ra = r_i[IW-1:0];
        if (r_kind == srdt_pkg::KIND_CHECK && r_j != '0) w_ra = r_j[IW-1:0];
    end

    // Compare the request (or the pair reference) against the read entry
    assign w_a = (r_kind == srdt_pkg::KIND_CHECK) ? r_ref : r_req;
    srdt_cmp u_cmp (.i_a(w_a), .i_b(r_rd), .o_cmp(w_cmp));

    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sorted    <= 1'b1;
            r_count     <= '0;
            r_we        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cfg_we) r_sorted <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind <= i_kind;
                        r_req  <= '{dev: i_device_id, base: i_base_address,
                                    len: i_region_length};
                        r_i    <= '0;
                        r_j    <= '0;
                        r_pos  <= r_count;
                        o_hit          <= 1'b0;
                        o_error        <= srdt_pkg::ERR_OK;
                        o_result_index <= 7'(r_count);
                        r_state        <= S_DONE;
                        case (i_kind)
                            srdt_pkg::KIND_ADD: begin
                                if (r_count >= CW'(srdt_pkg::CAPACITY)) begin
                                    o_error <= srdt_pkg::ERR_FULL;
                                end else if (!r_sorted || r_count == '0) begin
                                    r_we <= 1'b1;
                                    r_wa <= r_count[IW-1:0];
                                    r_wd <= '{dev: i_device_id, base: i_base_address,
                                              len: i_region_length};
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            srdt_pkg::KIND_REMOVE: begin
                                if ({1'b0, i_entry_index} >= 9'(r_count)) begin
                                    o_error <= srdt_pkg::ERR_RANGE;
                                end else begin
                                    r_i     <= CW'(i_entry_index) + 1'b1;
                                    o_result_index <= i_entry_index[6:0];
                                    r_state <= S_READ;
                                end
                            end
                            srdt_pkg::KIND_QUERY,
                            srdt_pkg::KIND_FIND,
                            srdt_pkg::KIND_CHECK: begin
                                if (i_kind == srdt_pkg::KIND_FIND)
                                    o_error <= srdt_pkg::ERR_MISS;
                                if (r_count != '0) r_state <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_READ;
                    case (r_kind)
                        srdt_pkg::KIND_ADD: begin
                            if (r_j == '0) begin
                                // Scan for the upper bound
                                if (w_cmp.less_ab || r_i + 1'b1 == r_count) begin
                                    r_pos <= w_cmp.less_ab ? r_i : r_count;
                                    r_j   <= r_count;
                                    r_state <= S_MOVE;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end else begin
                                // Shift the entry read from j-1 up into j
                                r_we    <= 1'b1;
                                r_wa    <= r_j[IW-1:0];
                                r_wd    <= r_rd;
                                r_j     <= r_j - 1'b1;
                                r_state <= S_MOVE;
                            end
                        end
                        srdt_pkg::KIND_REMOVE: begin
                            // Shift entry i down to i-1
                            r_we <= 1'b1;
                            r_wa <= IW'(r_i - 1'b1);
                            r_wd <= r_rd;
                            if (r_i + 1'b1 >= r_count) begin
                                r_count <= r_count - 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end
                        srdt_pkg::KIND_QUERY: begin
                            if (r_sorted) begin
                                if (w_cmp.less_ab) begin
                                    o_result_index <= 7'(r_i);
                                    o_hit   <= w_cmp.overlap;
                                    r_state <= S_DONE;
                                end
                            end else if (w_cmp.overlap) begin
                                o_result_index <= 7'(r_i);
                                o_hit   <= 1'b1;
                                r_state <= S_DONE;
                            end
                            if (r_i + 1'b1 == r_count) r_state <= S_DONE;
                            r_i <= r_i + 1'b1;
                        end
                        srdt_pkg::KIND_FIND: begin
                            if (w_cmp.equal) begin
                                o_result_index <= 7'(r_i);
                                o_hit   <= 1'b1;
                                o_error <= srdt_pkg::ERR_OK;
                                r_state <= S_DONE;
                            end
                            // Sorted: stop at the lower bound
                            if (r_sorted && !w_cmp.less_ba) r_state <= S_DONE;
                            if (r_i + 1'b1 == r_count) r_state <= S_DONE;
                            r_i <= r_i + 1'b1;
                        end
                        srdt_pkg::KIND_CHECK: begin
                            if (r_j == '0) begin
                                // Latched reference entry i
                                r_ref <= r_rd;
                                if (r_i + 1'b1 >= r_count) r_state <= S_DONE;
                                r_j <= r_i + 1'b1;
                            end else if (w_cmp.overlap) begin
                                o_hit   <= 1'b1;
                                r_state <= S_DONE;
                            end else if (r_sorted || r_j + 1'b1 == r_count) begin
                                r_i <= r_i + 1'b1;
                                r_j <= '0;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MOVE: begin
                    // Shift entries up from the top down to the insert point
                    if (r_j == r_pos) begin
                        r_we <= 1'b1;
                        r_wa <= r_pos[IW-1:0];
                        r_wd <= r_req;
                        r_count <= r_count + 1'b1;
                        o_result_index <= 7'(r_pos);
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_j - 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid) begin
                        o_out_valid <= 1'b1;
                    end else if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_entry_count = 7'(r_count);

    // Count never exceeds the table size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(srdt_pkg::CAPACITY))
        else $error("entry count above capacity");
    // Count changes only on entry to the result state
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_state == S_DONE))
        else $error("entry count changed outside a result");
    // Input is held off while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");
endmodule

@@ verif/tb_sorted_region_descriptor_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_region_descriptor_table: self-checking bench of the region table
// Drives a directed table of requests and then constrained random phases in
// sorted and unsorted mode. Every response beat is compared against a
// behavioral table model kept inside the bench or a fixed directed response.
// ----------------------------------------------------------------------------
module tb_sorted_region_descriptor_table;

    localparam logic [2:0] KIND_UNDEF_LO  = 3'd5;
    localparam logic [2:0] KIND_UNDEF_MID = 3'd6;
    localparam logic [2:0] KIND_UNDEF_HI  = 3'd7;
    localparam int         IDLE_LIMIT     = 60000;
    localparam int         N_DIRECTED     = 20;

    typedef struct packed {
        logic       hit;
        logic [6:0] ridx;
        logic [6:0] cnt;
        logic [1:0] err;
    } t_resp;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] dev;
        logic [63:0] base;
        logic [63:0] len;
        logic [7:0]  idx;
        bit          fixed;
        t_resp       resp;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_kind = '0;
    logic [15:0] i_device_id = '0;
    logic [63:0] i_base_address = '0;
    logic [63:0] i_region_length = '0;
    logic [7:0]  i_entry_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_hit;
    logic [6:0]  o_result_index;
    logic [6:0]  o_entry_count;
    logic [1:0]  o_error;

    sorted_region_descriptor_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_device_id     (i_device_id),
        .i_base_address  (i_base_address),
        .i_region_length (i_region_length),
        .i_entry_index   (i_entry_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_result_index  (o_result_index),
        .o_entry_count   (o_entry_count),
        .o_error         (o_error)
    );

    always #5 i_clk = ~i_clk;

    // Table model
    srdt_pkg::t_entry tbl [srdt_pkg::CAPACITY];
    int     tbl_cnt = 0;
    bit     tbl_sorted = 1'b1;

    t_resp  pending_resp [$];
    int     n_fail = 0;
    int     n_items = 0;
    int     n_resp = 0;
    int     n_hits = 0;
    int     n_full = 0;
    int     burst_left = 0;
    t_req   dir_rows [N_DIRECTED];

    function automatic bit end_le(logic [63:0] b, logic [63:0] l, logic [63:0] x);
        logic [64:0] s;
        s = {1'b0, b} + {1'b0, l};
        return s <= {1'b0, x};
    endfunction

    function automatic bit regions_hit(srdt_pkg::t_entry a, srdt_pkg::t_entry b);
        if (a.dev != b.dev)
            return 1'b0;
        return !(end_le(a.base, a.len, b.base) || end_le(b.base, b.len, a.base));
    endfunction

    function automatic bit region_lt(srdt_pkg::t_entry a, srdt_pkg::t_entry b);
        if (a.dev != b.dev)
            return a.dev < b.dev;
        if (a.base != b.base)
            return a.base < b.base;
        return a.len < b.len;
    endfunction

    function automatic int upper_slot(srdt_pkg::t_entry e);
        for (int i = 0; i < tbl_cnt; i++)
            if (region_lt(e, tbl[i]))
                return i;
        return tbl_cnt;
    endfunction

    // Apply one request to the table model and return its response
    function automatic t_resp apply_request(t_req r);
        t_resp            o;
        srdt_pkg::t_entry e;
        int               p;
        e = '{dev: r.dev, base: r.base, len: r.len};
        o = '{hit: 1'b0, ridx: 7'(tbl_cnt), cnt: '0, err: srdt_pkg::ERR_OK};
        case (r.kind)
            srdt_pkg::KIND_ADD: begin
                if (tbl_cnt >= srdt_pkg::CAPACITY) begin
                    o.err = srdt_pkg::ERR_FULL;
                end else begin
                    p = tbl_sorted ? upper_slot(e) : tbl_cnt;
                    for (int i = tbl_cnt; i > p; i--)
                        tbl[i] = tbl[i-1];
                    tbl[p] = e;
                    tbl_cnt++;
                    o.ridx = 7'(p);
                end
            end
            srdt_pkg::KIND_REMOVE: begin
                if (r.idx >= tbl_cnt) begin
                    o.err = srdt_pkg::ERR_RANGE;
                end else begin
                    for (int i = r.idx; i + 1 < tbl_cnt; i++)
                        tbl[i] = tbl[i+1];
                    tbl_cnt--;
                    o.ridx = r.idx[6:0];
                end
            end
            srdt_pkg::KIND_QUERY: begin
                if (tbl_sorted) begin
                    p = upper_slot(e);
                    o.ridx = 7'(p);
                    if (p < tbl_cnt && regions_hit(tbl[p], e))
                        o.hit = 1'b1;
                end else begin
                    for (int i = 0; i < tbl_cnt; i++)
                        if (!o.hit && regions_hit(tbl[i], e)) begin
                            o.hit = 1'b1;
                            o.ridx = 7'(i);
                        end
                end
            end
            srdt_pkg::KIND_FIND: begin
                p = tbl_cnt;
                if (tbl_sorted) begin
                    for (int i = tbl_cnt - 1; i >= 0; i--)
                        if (!region_lt(tbl[i], e))
                            p = i;
                    if (p < tbl_cnt && tbl[p] != e)
                        p = tbl_cnt;
                end else begin
                    for (int i = tbl_cnt - 1; i >= 0; i--)
                        if (tbl[i] == e)
                            p = i;
                end
                if (p < tbl_cnt) begin
                    o.hit = 1'b1;
                    o.ridx = 7'(p);
                end else begin
                    o.err = srdt_pkg::ERR_MISS;
                end
            end
            srdt_pkg::KIND_CHECK: begin
                for (int i = 0; i + 1 < tbl_cnt; i++) begin
                    if (tbl_sorted) begin
                        if (regions_hit(tbl[i+1], tbl[i]))
                            o.hit = 1'b1;
                    end else begin
                        for (int j = i + 1; j < tbl_cnt; j++)
                            if (regions_hit(tbl[j], tbl[i]))
                                o.hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        o.cnt = 7'(tbl_cnt);
        return o;
    endfunction

    function automatic t_req mk_req(logic [2:0] k, logic [15:0] d, logic [63:0] b,
                                    logic [63:0] l, logic [7:0] x);
        t_req r;
        r.kind = k;
        r.dev = d;
        r.base = b;
        r.len = l;
        r.idx = x;
        r.fixed = 1'b0;
        r.resp = '0;
        return r;
    endfunction

    function automatic t_req mk_fixed(logic [2:0] k, logic [15:0] d, logic [63:0] b,
                                      logic [63:0] l, logic [7:0] x, t_resp v);
        t_req r;
        r = mk_req(k, d, b, l, x);
        r.fixed = 1'b1;
        r.resp = v;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Build a random region: clustered, fully random, or near the top of memory
    function automatic srdt_pkg::t_entry rand_region();
        srdt_pkg::t_entry e;
        case ($urandom_range(0, 9))
            0, 1: e = '{dev: 16'($urandom), base: rand64(), len: rand64()};
            2: e = '{dev: 16'($urandom_range(0, 3)),
                     base: 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 300),
                     len: ($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 400)))};
            default: e = '{dev: 16'($urandom_range(0, 3)), base: 64'($urandom_range(0, 4095)),
                           len: 64'($urandom_range(0, 600))};
        endcase
        return e;
    endfunction

    function automatic t_req rand_request(int add_bias);
        t_req             r;
        srdt_pkg::t_entry e;
        int               sel;
        e = rand_region();
        r = mk_req(srdt_pkg::KIND_CHECK, e.dev, e.base, e.len, 8'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < add_bias)
            r.kind = srdt_pkg::KIND_ADD;
        else if (sel < add_bias + 20) begin
            r.kind = srdt_pkg::KIND_REMOVE;
            if (tbl_cnt > 0 && $urandom_range(0, 9) < 8)
                r.idx = 8'($urandom_range(0, tbl_cnt - 1));
        end else if (sel < add_bias + 42)
            r.kind = srdt_pkg::KIND_QUERY;
        else if (sel < add_bias + 60) begin
            r.kind = srdt_pkg::KIND_FIND;
            if (tbl_cnt > 0 && $urandom_range(0, 9) < 6) begin
                e = tbl[$urandom_range(0, tbl_cnt - 1)];
                r.dev = e.dev;
                r.base = e.base;
                r.len = e.len;
            end
        end else if (sel < add_bias + 67)
            r.kind = 3'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
        return r;
    endfunction

    // Present one request beat, hold it until accepted, then predict
    task automatic send_request(t_req r);
        int gap;
        i_in_valid      <= 1'b1;
        i_kind          <= r.kind;
        i_device_id     <= r.dev;
        i_base_address  <= r.base;
        i_region_length <= r.len;
        i_entry_index   <= r.idx;
        do @(posedge i_clk); while (o_in_stall);
        if (r.fixed) begin
            void'(apply_request(r));
            pending_resp.insert(pending_resp.size(), r.resp);
        end else begin
            pending_resp.insert(pending_resp.size(), apply_request(r));
        end
        if (r.kind == srdt_pkg::KIND_ADD && tbl_cnt == srdt_pkg::CAPACITY)
            n_full++;
        n_items++;
        // End the burst with a random gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic drain_responses();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending_resp.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(bit v);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tbl_sorted = v;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int bias;
        for (int k = 0; k < n; k++) begin
            bias = (tbl_cnt > 40) ? 18 : (tbl_cnt < 8 ? 45 : 30);
            send_request(rand_request(bias));
            if ($urandom_range(0, 199) == 0)
                drain_responses();
        end
    endtask

    // Fill the table to capacity, overflow it, then empty most of it
    task automatic fill_phase();
        srdt_pkg::t_entry e;
        while (tbl_cnt < srdt_pkg::CAPACITY) begin
            e = rand_region();
            send_request(mk_req(srdt_pkg::KIND_ADD, e.dev, e.base, e.len, 8'($urandom)));
        end
        for (int k = 0; k < 30; k++)
            send_request(rand_request(25));
        while (tbl_cnt > 4)
            send_request(mk_req(srdt_pkg::KIND_REMOVE, '0, '0, '0,
                                8'($urandom_range(0, tbl_cnt - 1))));
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch %s got %0d expected %0d", $time, what, got, want);
        n_fail++;
    endtask

    // Receiver stall pattern: random stall modes, redrawn periodically
    int stall_mode = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= (stall_tick % 7 < 3);
        endcase
    end

    // Compare each response beat with the oldest prediction
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resp.size() == 0) begin
                $display("%0t: response beat with nothing pending", $time);
                n_fail++;
            end else begin
                want = pending_resp.pop_front();
                n_resp++;
                if (o_hit)
                    n_hits++;
                if (o_hit !== want.hit)
                    report_mismatch("hit", o_hit, want.hit);
                if (o_result_index !== want.ridx)
                    report_mismatch("result_index", o_result_index, want.ridx);
                if (o_entry_count !== want.cnt)
                    report_mismatch("entry_count", o_entry_count, want.cnt);
                if (o_error !== want.err)
                    report_mismatch("error", o_error, want.err);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

    initial begin
        // Empty-table cases first, then a small sorted table
        dir_rows[0]  = mk_fixed(srdt_pkg::KIND_FIND, 16'h0, 64'h0, 64'h0, 8'h0,
                                '{1'b0, 7'd0, 7'd0, srdt_pkg::ERR_MISS});
        dir_rows[1]  = mk_fixed(srdt_pkg::KIND_REMOVE, 16'h0, 64'h0, 64'h0, 8'h0,
                                '{1'b0, 7'd0, 7'd0, srdt_pkg::ERR_RANGE});
        dir_rows[2]  = mk_fixed(srdt_pkg::KIND_QUERY, 16'hFFFF, ALL1, ALL1, 8'hFF,
                                '{1'b0, 7'd0, 7'd0, srdt_pkg::ERR_OK});
        dir_rows[3]  = mk_fixed(srdt_pkg::KIND_CHECK, 16'h0, 64'h0, 64'h0, 8'h0,
                                '{1'b0, 7'd0, 7'd0, srdt_pkg::ERR_OK});
        dir_rows[4]  = mk_fixed(KIND_UNDEF_LO, 16'h1, 64'h1, 64'h1, 8'h1,
                                '{1'b0, 7'd0, 7'd0, srdt_pkg::ERR_OK});
        dir_rows[5]  = mk_fixed(KIND_UNDEF_HI, 16'hFFFF, ALL1, ALL1, 8'hFF,
                                '{1'b0, 7'd0, 7'd0, srdt_pkg::ERR_OK});
        dir_rows[6]  = mk_fixed(srdt_pkg::KIND_ADD, 16'hFFFF, ALL1, ALL1, 8'hFF,
                                '{1'b0, 7'd0, 7'd1, srdt_pkg::ERR_OK});
        dir_rows[7]  = mk_fixed(srdt_pkg::KIND_ADD, 16'h0, 64'h0, 64'h0, 8'h0,
                                '{1'b0, 7'd0, 7'd2, srdt_pkg::ERR_OK});
        dir_rows[8]  = mk_req(srdt_pkg::KIND_ADD, 16'h0, 64'h100, 64'h100, 8'h0);
        dir_rows[9]  = mk_req(srdt_pkg::KIND_ADD, 16'h0, 64'h180, 64'h10, 8'h0);
        dir_rows[10] = mk_req(srdt_pkg::KIND_QUERY, 16'h0, 64'h1FF, 64'h1, 8'h0);
        dir_rows[11] = mk_req(srdt_pkg::KIND_FIND, 16'h0, 64'h100, 64'h100, 8'h0);
        dir_rows[12] = mk_req(srdt_pkg::KIND_FIND, 16'h0, 64'h100, 64'h101, 8'h0);
        dir_rows[13] = mk_req(srdt_pkg::KIND_CHECK, 16'h0, 64'h0, 64'h0, 8'h0);
        // Range ends at the very top of memory without wrapping
        dir_rows[14] = mk_req(srdt_pkg::KIND_QUERY, 16'hFFFF, 64'h0, ALL1, 8'h0);
        dir_rows[15] = mk_req(srdt_pkg::KIND_QUERY, 16'hFFFF, ALL1 - 64'h1, 64'h1, 8'h0);
        dir_rows[16] = mk_fixed(srdt_pkg::KIND_REMOVE, 16'h0, 64'h0, 64'h0, 8'hFF,
                                '{1'b0, 7'd4, 7'd4, srdt_pkg::ERR_RANGE});
        dir_rows[17] = mk_req(srdt_pkg::KIND_REMOVE, 16'h0, 64'h0, 64'h0, 8'h1);
        dir_rows[18] = mk_req(KIND_UNDEF_MID, 16'h5, 64'h5, 64'h5, 8'h5);
        dir_rows[19] = mk_req(srdt_pkg::KIND_QUERY, 16'h0, 64'h150, 64'h0, 8'h0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(1'b1);
        for (int k = 0; k < N_DIRECTED; k++)
            send_request(dir_rows[k]);

        write_mode(1'b0);
        random_phase(250);
        write_mode(1'b1);
        random_phase(200);
        fill_phase();
        write_mode(1'b0);
        fill_phase();
        random_phase(200);
        write_mode(1'b1);
        random_phase(280);

        drain_responses();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests, %0d responses, %0d hits, %0d times at capacity",
                 n_items, n_resp, n_hits, n_full);
        $display("Modes sorted and unsorted, with table fill, overflow and drain");
        if (n_fail == 0 && pending_resp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/srdt_pkg.sv
rtl/srdt_cmp.sv
rtl/sorted_region_descriptor_table.sv
verif/tb_sorted_region_descriptor_table.sv
